// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks sampled on clk, held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr holds at every sampled edge
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// pre at an edge implies post at the same edge
`define ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// pre at an edge implies post at the next edge
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPL(label, pre, post, msg)
`define ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

// ===== rtl/potq_pkg.sv =====
// ---------------------------------------------------------------------------
// potq_pkg
// Request modes, status codes and default sizes of the task queue.
// ---------------------------------------------------------------------------
`default_nettype none

package potq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int ID_BITS_DEF   = 8;
  localparam int PRIO_BITS_DEF = 8;
  localparam int CNT_OUT_W     = 5;

  localparam logic [2:0] MODE_APPEND = 3'd0;
  localparam logic [2:0] MODE_PRIO   = 3'd1;
  localparam logic [2:0] MODE_FRONT  = 3'd2;
  localparam logic [2:0] MODE_REMOVE = 3'd3;
  localparam logic [2:0] MODE_POP    = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SEEK    = 7'b0000010,
    S_TEST    = 7'b0000100,
    S_MOVE_RD = 7'b0001000,
    S_MOVE_WR = 7'b0010000,
    S_PUT     = 7'b0100000,
    S_FIN     = 7'b1000000
  } potq_state_t;

endpackage

`default_nettype wire

// ===== rtl/priority_ordered_task_queue.sv =====
// ---------------------------------------------------------------------------
// priority_ordered_task_queue
// Ordered list of task entries in a RAM with one read and one write port, walked by a sequencer.
// ---------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tuser: mode; tdata: task_id, task_priority
//  out_    | out | out_tvalid/tready  | tuser: status; tdata: id, priority, count
//
//  Search visits each entry in S_SEEK then S_TEST, and a shift moves each
//  entry in S_MOVE_RD then S_MOVE_WR, as the RAM read is registered;
//  insert by priority is the longest request.
//  in_tready is high only while the sequencer is idle; a finished result waits
//  in the output register, and the sequencer stalls in its last state only
//  while an earlier result still waits there.
//  Reset empties the list at once; RAM contents are left as they are.
// ---------------------------------------------------------------------------
`default_nettype none

module priority_ordered_task_queue
  import potq_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF,
  localparam int IN_W     = ID_BITS + PRIO_BITS,
  localparam int IN_TW    = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W    = ID_BITS + PRIO_BITS + CNT_OUT_W,
  localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_TW-1:0]  in_tdata,   // task_id, task_priority
  input  wire logic [2:0]        in_tuser,   // mode
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_TW-1:0]      out_tdata,  // out_task_id, out_priority, entry_count
  output logic [1:0]             out_tuser   // status
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // entry RAM: id in the low bits, priority above
  logic [IN_W-1:0] mem [DEPTH];
  logic [IN_W-1:0] rd_r;
  logic [IDX_W-1:0] ra_c, wa_c;
  logic            we_c;
  logic [IN_W-1:0] wd_c;

  potq_state_t state_r, state_nxt;
  logic [2:0]           mode_r, mode_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0]     walk_r, walk_nxt;
  logic                 ins_r, ins_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [1:0]           stat_r, stat_nxt;
  logic [ID_BITS-1:0]   rid_r, rid_nxt;
  logic [PRIO_BITS-1:0] rprio_r, rprio_nxt;

  logic                 ov_r, ov_nxt;
  logic [1:0]           o_stat_r, o_stat_nxt;
  logic [ID_BITS-1:0]   o_id_r, o_id_nxt;
  logic [PRIO_BITS-1:0] o_prio_r, o_prio_nxt;
  logic [CNT_W-1:0]     o_cnt_r, o_cnt_nxt;

  logic [ID_BITS-1:0]   in_id;
  logic [PRIO_BITS-1:0] in_prio;
  logic [ID_BITS-1:0]   slot_id;
  logic [PRIO_BITS-1:0] slot_prio;
  logic                 full, hit;
  logic [CNT_W-1:0]     walk_dn, walk_up;
  logic [CNT_W:0]       walk_up_w;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;
  logic [OUT_W-1:0]     out_pack;

  assign in_id     = in_tdata[ID_BITS-1:0];
  assign in_prio   = in_tdata[IN_W-1:ID_BITS];
  assign slot_id   = rd_r[ID_BITS-1:0];
  assign slot_prio = rd_r[IN_W-1:ID_BITS];
  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign walk_dn   = walk_r - 1'b1;
  assign walk_up   = walk_r + 1'b1;
  assign walk_up_w = {1'b0, walk_r} + 1'b1;

  // shared compare unit
  always_comb begin
    case (mode_r)
      MODE_PRIO:   hit = (prio_r < slot_prio) || ((pos_r == '0) && (prio_r == slot_prio));
      MODE_REMOVE: hit = (id_r == slot_id);
      MODE_POP:    hit = 1'b1;
      default:     hit = 1'b0;
    endcase
  end

  // RAM port selects
  always_comb begin
    ra_c = pos_r[IDX_W-1:0];
    if (state_r == S_MOVE_RD) begin
      ra_c = ins_r ? walk_dn[IDX_W-1:0] : walk_up[IDX_W-1:0];
    end
    we_c = (state_r == S_MOVE_WR) || (state_r == S_PUT);
    wa_c = (state_r == S_PUT) ? pos_r[IDX_W-1:0] : walk_r[IDX_W-1:0];
    wd_c = (state_r == S_PUT) ? {prio_r, id_r} : rd_r;
  end

  always_ff @(posedge clk) begin
    if (we_c) begin
      mem[wa_c] <= wd_c;
    end
    rd_r <= mem[ra_c];
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    id_nxt     = id_r;
    prio_nxt   = prio_r;
    pos_nxt    = pos_r;
    walk_nxt   = walk_r;
    ins_nxt    = ins_r;
    cnt_nxt    = cnt_r;
    stat_nxt   = stat_r;
    rid_nxt    = rid_r;
    rprio_nxt  = rprio_r;
    ov_nxt     = ov_r && !out_tready;
    o_stat_nxt = o_stat_r;
    o_id_nxt   = o_id_r;
    o_prio_nxt = o_prio_r;
    o_cnt_nxt  = o_cnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = in_tuser;
          id_nxt    = in_id;
          prio_nxt  = in_prio;
          stat_nxt  = ST_OK;
          rid_nxt   = '0;
          rprio_nxt = '0;
          pos_nxt   = '0;
          walk_nxt  = cnt_r;
          ins_nxt   = 1'b1;
          unique case (in_tuser)
            MODE_APPEND: begin
              if (full) begin
                stat_nxt  = ST_FULL;
                state_nxt = S_FIN;
              end else begin
                pos_nxt   = cnt_r;
                state_nxt = S_PUT;
              end
            end
            MODE_PRIO: begin
              if (full) begin
                stat_nxt  = ST_FULL;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_SEEK;
              end
            end
            MODE_FRONT: begin
              if (full) begin
                stat_nxt  = ST_FULL;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_MOVE_RD;
              end
            end
            MODE_REMOVE: state_nxt = S_SEEK;
            MODE_POP: begin
              if (cnt_r == '0) begin
                stat_nxt  = ST_EMPTY;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_SEEK;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_SEEK: begin
        // walked off the end: append for inserts, miss for removes
        if (pos_r == cnt_r) begin
          if (mode_r == MODE_REMOVE) begin
            stat_nxt  = ST_NOT_FOUND;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_PUT;
          end
        end else begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (!hit) begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_SEEK;
        end else if (mode_r == MODE_PRIO) begin
          walk_nxt  = cnt_r;
          ins_nxt   = 1'b1;
          state_nxt = S_MOVE_RD;
        end else begin
          rid_nxt   = slot_id;
          rprio_nxt = slot_prio;
          walk_nxt  = pos_r;
          ins_nxt   = 1'b0;
          state_nxt = S_MOVE_RD;
        end
      end
      S_MOVE_RD: begin
        if (ins_r) begin
          if (walk_r == pos_r) begin
            state_nxt = S_PUT;
          end else begin
            state_nxt = S_MOVE_WR;
          end
        end else if (walk_up_w >= {1'b0, cnt_r}) begin
          // gap closed at the tail: drop one entry
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_MOVE_WR;
        end
      end
      S_MOVE_WR: begin
        walk_nxt  = ins_r ? walk_dn : walk_up;
        state_nxt = S_MOVE_RD;
      end
      S_PUT: begin
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!ov_r || out_tready) begin
          ov_nxt     = 1'b1;
          o_stat_nxt = stat_r;
          o_id_nxt   = rid_r;
          o_prio_nxt = rprio_r;
          o_cnt_nxt  = cnt_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    id_r     <= id_nxt;
    prio_r   <= prio_nxt;
    pos_r    <= pos_nxt;
    walk_r   <= walk_nxt;
    ins_r    <= ins_nxt;
    stat_r   <= stat_nxt;
    rid_r    <= rid_nxt;
    rprio_r  <= rprio_nxt;
    o_stat_r <= o_stat_nxt;
    o_id_r   <= o_id_nxt;
    o_prio_r <= o_prio_nxt;
    o_cnt_r  <= o_cnt_nxt;
  end

  assign cnt_ext    = (CNT_W + CNT_OUT_W)'(o_cnt_r);
  assign out_pack   = {cnt_ext[CNT_OUT_W-1:0], o_prio_r, o_id_r};
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = OUT_TW'(out_pack);
  assign out_tuser  = o_stat_r;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(DEPTH), "entry count beyond depth")
  `ASSERT_NEXT(a_put_grows, state_r == S_PUT, cnt_r == $past(cnt_r) + 1'b1, "insert did not grow list")
  `ASSERT_NEXT(a_idle_holds, state_r == S_IDLE, cnt_r == $past(cnt_r), "list size moved while idle")
  `ASSERT_IMPL(a_full_count, ov_r && (o_stat_r == ST_FULL), o_cnt_r == CNT_W'(DEPTH), "full status on list not full")

endmodule

`default_nettype wire

// ===== dv/priority_ordered_task_queue_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ordered_task_queue_test
// Self-checking bench for the ordered task queue: a directed table walks the
// empty, full, duplicate-id and unused-mode corners, then random phases that
// fill, drain and churn the list run against an in-bench list predictor.
// ----------------------------------------------------------------------------

module priority_ordered_task_queue_test
  import potq_pkg::*;
();

  localparam int DEPTH  = DEPTH_DEF;
  localparam int IN_TW  = ((ID_BITS_DEF + PRIO_BITS_DEF + 7) / 8) * 8;
  localparam int OUT_TW = ((ID_BITS_DEF + PRIO_BITS_DEF + CNT_OUT_W + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1550;

  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [1:0]           status;
    logic [7:0]           task_id;
    logic [7:0]           prio;
    logic [CNT_OUT_W-1:0] count;
  } outcome_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] task_id;
    logic [7:0] prio;
    bit         typed;
    outcome_t   want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_TW-1:0]  in_tdata = '0;    // task_id, task_priority
  logic [2:0]        in_tuser = '0;    // mode
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;        // out_task_id, out_priority, entry_count
  logic [1:0]        out_tuser;        // status

  // list as the queue should hold it, head at index 0
  logic [7:0] list_ids[$];
  logic [7:0] list_prios[$];
  outcome_t   pending_results[$];
  int         mismatches = 0;
  bit         calm = 1'b0;

  stim_row_t directed_rows[27];

  priority_ordered_task_queue DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("priority_ordered_task_queue_test: FAIL");
    $finish;
  end

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 22);
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic outcome_t apply_request(logic [2:0] mode, logic [7:0] id,
                                             logic [7:0] prio);
    outcome_t res;
    int pos;
    res = '{ST_OK, 8'h00, 8'h00, '0};
    case (mode) inside
      MODE_APPEND, MODE_PRIO, MODE_FRONT: begin
        if (list_ids.size() >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (mode == MODE_APPEND) begin
            pos = list_ids.size();
          end else if (mode == MODE_FRONT || list_ids.size() == 0 || prio <= list_prios[0]) begin
            pos = 0;
          end else begin
            // settle behind every entry at least as urgent as this one
            pos = 1;
            while (pos < list_ids.size() && prio >= list_prios[pos]) pos++;
          end
          list_ids.insert(pos, id);
          list_prios.insert(pos, prio);
        end
      end
      MODE_REMOVE: begin
        pos = 0;
        while (pos < list_ids.size() && list_ids[pos] != id) pos++;
        if (pos < list_ids.size()) begin
          res.task_id = list_ids[pos];
          res.prio    = list_prios[pos];
          list_ids.delete(pos);
          list_prios.delete(pos);
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      MODE_POP: begin
        if (list_ids.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.task_id = list_ids.pop_front();
          res.prio    = list_prios.pop_front();
        end
      end
      default: ;
    endcase
    res.count = CNT_OUT_W'(list_ids.size());
    return res;
  endfunction

  // Present one item; returns once it has been accepted, at the next falling edge.
  task automatic send_request(logic [2:0] mode, logic [7:0] id, logic [7:0] prio,
                              bit typed, outcome_t want);
    outcome_t predicted;
    if (!calm && $urandom_range(99) < 22) begin
      in_tvalid = 1'b0;
      if ($urandom_range(9) == 0) repeat ($urandom_range(10, 50)) @(negedge clk);
      else repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = {prio, id};
    do @(posedge clk); while (!in_tready);
    predicted = apply_request(mode, id, prio);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    outcome_t got;
    outcome_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[7:0], out_tdata[15:8], out_tdata[16 +: CNT_OUT_W]};
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", got, 0);
      end else begin
        exp = pending_results.pop_front();
        if (got.status !== exp.status) report_mismatch("status", got.status, exp.status);
        if (got.task_id !== exp.task_id) report_mismatch("task id", got.task_id, exp.task_id);
        if (got.prio !== exp.prio) report_mismatch("priority", got.prio, exp.prio);
        if (got.count !== exp.count) report_mismatch("entry count", got.count, exp.count);
      end
    end
  end

  initial begin
    int         accepted;
    int         phase;
    int         phase_len;
    int         pick;
    int         guard;
    logic [2:0] mode;
    logic [7:0] id;
    logic [7:0] prio;

    directed_rows = '{
      '{MODE_POP,       8'h00, 8'h00, 1'b1, '{ST_EMPTY,     8'h00, 8'h00, 5'd0}},
      '{MODE_REMOVE,    8'h05, 8'h00, 1'b1, '{ST_NOT_FOUND, 8'h00, 8'h00, 5'd0}},
      '{MODE_UNUSED_LO, 8'hff, 8'hff, 1'b1, '{ST_OK,        8'h00, 8'h00, 5'd0}},
      '{MODE_UNUSED_HI, 8'h00, 8'h00, 1'b1, '{ST_OK,        8'h00, 8'h00, 5'd0}},
      '{MODE_APPEND,    8'hff, 8'hff, 1'b1, '{ST_OK,        8'h00, 8'h00, 5'd1}},
      '{MODE_PRIO,      8'h00, 8'h00, 1'b1, '{ST_OK,        8'h00, 8'h00, 5'd2}},
      '{MODE_FRONT,     8'h80, 8'h80, 1'b0, '0},
      '{MODE_PRIO,      8'h10, 8'h80, 1'b0, '0},
      '{MODE_PRIO,      8'h11, 8'h81, 1'b0, '0},
      '{MODE_PRIO,      8'h12, 8'hff, 1'b0, '0},
      '{MODE_PRIO,      8'h13, 8'h00, 1'b0, '0},
      '{MODE_FRONT,     8'h12, 8'h40, 1'b0, '0},
      '{MODE_APPEND,    8'h55, 8'haa, 1'b0, '0},
      '{MODE_APPEND,    8'haa, 8'h55, 1'b0, '0},
      '{MODE_PRIO,      8'h01, 8'hfe, 1'b0, '0},
      '{MODE_PRIO,      8'h7f, 8'h7f, 1'b0, '0},
      '{MODE_FRONT,     8'hfe, 8'h01, 1'b0, '0},
      '{MODE_PRIO,      8'h20, 8'h20, 1'b0, '0},
      '{MODE_APPEND,    8'h21, 8'hff, 1'b0, '0},
      '{MODE_PRIO,      8'h22, 8'h81, 1'b0, '0},
      '{MODE_APPEND,    8'h30, 8'h30, 1'b1, '{ST_FULL,      8'h00, 8'h00, 5'd16}},
      '{MODE_PRIO,      8'h31, 8'h00, 1'b1, '{ST_FULL,      8'h00, 8'h00, 5'd16}},
      '{MODE_FRONT,     8'h32, 8'hff, 1'b1, '{ST_FULL,      8'h00, 8'h00, 5'd16}},
      '{MODE_REMOVE,    8'h12, 8'h00, 1'b0, '0},
      '{MODE_POP,       8'h00, 8'h00, 1'b0, '0},
      '{MODE_REMOVE,    8'hab, 8'h00, 1'b1, '{ST_NOT_FOUND, 8'h00, 8'h00, 5'd14}},
      '{MODE_REMOVE,    8'h12, 8'h00, 1'b0, '0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      send_request(directed_rows[r].mode, directed_rows[r].task_id, directed_rows[r].prio,
                   directed_rows[r].typed, directed_rows[r].want);
    end

    accepted = 0;
    while (accepted < RANDOM_ITEMS) begin
      // phases: 0 fill, 1 drain, 2 churn
      phase     = $urandom_range(2);
      phase_len = $urandom_range(10, 60);
      repeat (phase_len) begin
        calm = (accepted >= 300 && accepted < 600);
        if (accepted == 800) begin
          // hold off until the queue has answered everything
          in_tvalid = 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
        end
        pick = $urandom_range(99);
        if (pick < 4) begin
          mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        end else if ((phase == 0 && pick < 88) || (phase == 1 && pick < 16)
                     || (phase == 2 && pick < 52)) begin
          case ($urandom_range(3))
            0: mode = MODE_APPEND;
            1: mode = MODE_FRONT;
            default: mode = MODE_PRIO;
          endcase
        end else begin
          mode = $urandom_range(1) ? MODE_REMOVE : MODE_POP;
        end

        id = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
        if (mode == MODE_REMOVE && list_ids.size() != 0 && $urandom_range(3) != 0) begin
          id = list_ids[$urandom_range(list_ids.size() - 1)];
        end
        case ($urandom_range(9)) inside
          [0:3]:   prio = 8'($urandom_range(7));
          4:       prio = $urandom_range(1) ? 8'hff : 8'h00;
          default: prio = 8'($urandom_range(255));
        endcase

        send_request(mode, id, prio, 1'b0, '0);
        accepted++;
      end
    end

    in_tvalid = 1'b0;
    calm = 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (2 * DEPTH + 8) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("priority_ordered_task_queue_test: PASS");
    end else begin
      $display("priority_ordered_task_queue_test: FAIL");
    end
    $finish;
  end

endmodule
